// ===== hw/rtl/huart_pkg.sv =====
// types, constants and reset values for the half-duplex uart engine
package huart_pkg;

    localparam int BUFFER_DEPTH_DEF = 128;

    localparam logic [15:0] RESET_BIT_COUNTS   = 16'd217;
    localparam logic [15:0] RESET_HUNT_COUNTS  = 16'd55;
    localparam logic [15:0] RESET_START_COUNTS = 16'd178;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_SEND  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] REG_DIRECTION    = 2'd0;
    localparam logic [1:0] REG_BIT_COUNTS   = 2'd1;
    localparam logic [1:0] REG_HUNT_COUNTS  = 2'd2;
    localparam logic [1:0] REG_START_COUNTS = 2'd3;

    localparam logic [3:0] STEP_IDLE      = 4'd0;
    localparam logic [3:0] STEP_FIRST     = 4'd1;
    localparam logic [3:0] STEP_STOP      = 4'd1;
    localparam logic [3:0] STEP_LAST_DATA = 4'd9;
    localparam logic [3:0] STEP_START     = 4'd10;

    localparam logic [7:0] SHIFT_IDLE = 8'hFF;

    typedef struct packed {
        logic        rx_en;
        logic        tx_en;
        logic [3:0]  bit_step;
        logic [7:0]  shift_byte;
        logic [15:0] tick_left;
        logic [7:0]  rx_count;
        logic        ready;
        logic        line_out;
    } t_state;

    typedef struct packed {
        logic [15:0] bit_counts;
        logic [15:0] hunt_counts;
        logic [15:0] start_counts;
    } t_counts;

    typedef struct packed {
        logic       txd;
        logic       tx_ready;
        logic       send_accepted;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [6:0] rx_slot;
        logic       rx_full;
    } t_result;

endpackage

// ===== hw/rtl/huart_step.sv =====
// next state and result of one item for the half-duplex uart engine
module huart_step #(
    parameter int BUFFER_DEPTH = huart_pkg::BUFFER_DEPTH_DEF
) (
    input  huart_pkg::t_state  i_state,
    input  huart_pkg::t_counts i_counts,
    input  logic [1:0]         i_kind,
    input  logic               i_rxd,
    input  logic [7:0]         i_tx_byte,
    output huart_pkg::t_state  o_state,
    output huart_pkg::t_result o_result
);
    import huart_pkg::*;

    localparam logic [7:0] DEPTH_LIMIT = 8'(BUFFER_DEPTH);

    t_state     n_st;
    logic       accepted;
    logic       valid;
    logic [7:0] byte_out;
    logic [6:0] slot_out;
    logic [3:0] step_up;
    logic [3:0] step_dn;
    logic [7:0] shift_rx;
    logic [7:0] shift_tx;
    logic [15:0] tick_dec;

    always_comb begin
        n_st     = i_state;
        accepted = 1'b0;
        valid    = 1'b0;
        byte_out = 8'd0;
        slot_out = 7'd0;
        step_up  = i_state.bit_step + 4'd1;
        step_dn  = i_state.bit_step - 4'd1;
        shift_rx = {i_rxd, i_state.shift_byte[7:1]};
        shift_tx = i_state.shift_byte;
        tick_dec = (i_state.tick_left != 16'd0) ? i_state.tick_left - 16'd1 : 16'd0;

        case (i_kind)
            KIND_TICK: begin
                n_st.tick_left = tick_dec;
                if (tick_dec == 16'd0) begin
                    if (i_state.rx_en) begin
                        if (i_state.bit_step == STEP_IDLE) begin
                            if (i_rxd) begin
                                // false start, keep hunting
                                n_st.tx_en     = 1'b0;
                                n_st.tick_left = i_counts.hunt_counts;
                            end else begin
                                n_st.tick_left  = i_counts.bit_counts;
                                n_st.bit_step   = STEP_FIRST;
                                n_st.shift_byte = 8'd0;
                            end
                        end else if (step_up <= STEP_LAST_DATA) begin
                            n_st.tick_left  = i_counts.bit_counts;
                            n_st.bit_step   = step_up;
                            n_st.shift_byte = shift_rx;
                            if (step_up == STEP_LAST_DATA) begin
                                if (i_state.rx_count < DEPTH_LIMIT) begin
                                    valid         = 1'b1;
                                    byte_out      = shift_rx;
                                    slot_out      = i_state.rx_count[6:0];
                                    n_st.rx_count = i_state.rx_count + 8'd1;
                                end else begin
                                    n_st.rx_en = 1'b0;
                                end
                            end
                        end else begin
                            n_st.tick_left = i_counts.hunt_counts;
                            n_st.bit_step  = STEP_IDLE;
                        end
                    end else if (i_state.tx_en) begin
                        n_st.tick_left = i_counts.bit_counts;
                        if (step_dn > STEP_LAST_DATA) begin
                            // idle clamp keeps shifting ones
                            step_dn  = STEP_LAST_DATA;
                            shift_tx = SHIFT_IDLE;
                        end
                        n_st.bit_step = step_dn;
                        if (step_dn > STEP_STOP) begin
                            n_st.line_out   = shift_tx[0];
                            n_st.shift_byte = {1'b0, shift_tx[7:1]};
                        end else begin
                            n_st.line_out   = 1'b1;
                            n_st.shift_byte = shift_tx;
                            if (step_dn == STEP_IDLE) begin
                                n_st.ready = 1'b1;
                            end
                        end
                    end else begin
                        n_st.tick_left = i_counts.bit_counts;
                    end
                end
            end
            KIND_SEND: begin
                if (i_state.tx_en && !i_state.rx_en && i_state.ready) begin
                    accepted        = 1'b1;
                    n_st.tick_left  = i_counts.start_counts;
                    n_st.shift_byte = i_tx_byte;
                    n_st.bit_step   = STEP_START;
                    n_st.line_out   = 1'b0;
                    n_st.ready      = 1'b0;
                end
            end
            KIND_CLEAR: begin
                n_st.rx_count = 8'd0;
            end
            default: begin
            end
        endcase
    end

    assign o_state                = n_st;
    assign o_result.txd           = n_st.line_out;
    assign o_result.tx_ready      = n_st.ready;
    assign o_result.send_accepted = accepted;
    assign o_result.rx_valid      = valid;
    assign o_result.rx_byte       = byte_out;
    assign o_result.rx_slot       = slot_out;
    assign o_result.rx_full       = !n_st.rx_en && !n_st.tx_en;

endmodule

// ===== hw/rtl/half_duplex_uart_engine_unit.sv =====
// top level of the half-duplex 8n1 uart engine with input and result registers
// Half-duplex 8N1 UART engine stepped by timer tick items. Each accepted item
// (tick, send byte or clear receive count) yields exactly one result carrying
// the transmit line level, tx_ready, send acceptance, any received byte with
// its buffer slot, and the buffer-full stop flag. Throughput is one item per
// clock unless i_ready stalls the result; an item goes from the input register
// through the combinational step logic into the result register, which frees
// the input side while a result waits for ready. The user must write counter
// registers and direction through the plain write port only while no item is
// in flight (not enforced by the block); writing direction restarts that mode.
module half_duplex_uart_engine_unit #(
    parameter int BUFFER_DEPTH = huart_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic        i_rxd,
    input  logic [7:0]  i_tx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_txd,
    output logic        o_tx_ready,
    output logic        o_send_accepted,
    output logic        o_rx_valid,
    output logic [7:0]  o_rx_byte,
    output logic [6:0]  o_rx_slot,
    output logic        o_rx_full
);
    import huart_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_counts    r_counts;
    t_result    r_out;
    t_result    n_out;
    logic       r_in_valid;
    logic [1:0] r_kind;
    logic       r_rxd;
    logic [7:0] r_tx_byte;
    logic       r_out_valid;
    logic       out_free;
    logic       step_fire;

    assign out_free  = !r_out_valid || i_ready;
    assign step_fire = r_in_valid && out_free;
    assign o_ready   = !r_in_valid || out_free;

    huart_step #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_step (
        .i_state  (r_state),
        .i_counts (r_counts),
        .i_kind   (r_kind),
        .i_rxd    (r_rxd),
        .i_tx_byte(r_tx_byte),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (out_free) begin
            r_in_valid <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_kind    <= i_kind;
            r_rxd     <= i_rxd;
            r_tx_byte <= i_tx_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (step_fire) begin
            r_out <= n_out;
        end
    end

    // engine state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.rx_en      <= 1'b1;
            r_state.tx_en      <= 1'b0;
            r_state.bit_step   <= STEP_IDLE;
            r_state.shift_byte <= 8'd0;
            r_state.tick_left  <= RESET_HUNT_COUNTS;
            r_state.rx_count   <= 8'd0;
            r_state.ready      <= 1'b1;
            r_state.line_out   <= 1'b1;
            r_counts.bit_counts   <= RESET_BIT_COUNTS;
            r_counts.hunt_counts  <= RESET_HUNT_COUNTS;
            r_counts.start_counts <= RESET_START_COUNTS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DIRECTION: begin
                    r_state.bit_step <= STEP_IDLE;
                    if (i_cfg_data[0]) begin
                        r_state.tx_en <= 1'b1;
                        r_state.rx_en <= 1'b0;
                        r_state.ready <= 1'b1;
                    end else begin
                        r_state.rx_en     <= 1'b1;
                        r_state.tx_en     <= 1'b0;
                        r_state.tick_left <= r_counts.hunt_counts;
                    end
                end
                REG_BIT_COUNTS:   r_counts.bit_counts   <= i_cfg_data;
                REG_HUNT_COUNTS:  r_counts.hunt_counts  <= i_cfg_data;
                REG_START_COUNTS: r_counts.start_counts <= i_cfg_data;
                default: begin
                end
            endcase
        end else if (step_fire) begin
            r_state <= n_state;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_txd           = r_out.txd;
    assign o_tx_ready      = r_out.tx_ready;
    assign o_send_accepted = r_out.send_accepted;
    assign o_rx_valid      = r_out.rx_valid;
    assign o_rx_byte       = r_out.rx_byte;
    assign o_rx_slot       = r_out.rx_slot;
    assign o_rx_full       = r_out.rx_full;

    a_one_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state.rx_en && r_state.tx_en))
        else $error("receive and transmit enabled together");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bit_step <= STEP_START)
        else $error("bit step out of range");

    a_rx_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rx_valid |-> !o_rx_full && !o_send_accepted)
        else $error("byte reported while stopped or with a send");

    a_send_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_send_accepted |-> !o_txd && !o_tx_ready)
        else $error("accepted send did not drive the start bit");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire |=> o_valid)
        else $error("stepped item produced no result");

endmodule
